@@ rtl/csv_pkg.sv @@
package csv_pkg;

    localparam int RootW  = 4;
    localparam int QualW  = 4;
    localparam int ExtW   = 15;
    localparam int PitchW = 7;
    localparam int NumPc  = 12;
    localparam int IdxW   = $clog2(NumPc);

    localparam logic [PitchW-1:0] BassBase    = PitchW'(36);
    localparam logic [PitchW-1:0] TrebleFloor = PitchW'(60);
    localparam logic [PitchW-1:0] Octave      = PitchW'(NumPc);

    typedef enum logic [QualW-1:0] {
        Q_MAJ  = 4'd0,
        Q_MIN  = 4'd1,
        Q_DIM  = 4'd2,
        Q_HDIM = 4'd3,
        Q_AUG  = 4'd4,
        Q_SUS2 = 4'd5,
        Q_SUS4 = 4'd6,
        Q_POW  = 4'd7
    } t_quality;

    localparam int F_B5   = 0;
    localparam int F_S5   = 1;
    localparam int F_OM3  = 2;
    localparam int F_MAJ7 = 3;
    localparam int F_MIN7 = 4;
    localparam int F_DIM7 = 5;
    localparam int F_ADD6 = 6;
    localparam int F_B9   = 7;
    localparam int F_9    = 8;
    localparam int F_S9   = 9;
    localparam int F_11   = 10;
    localparam int F_S11  = 11;
    localparam int F_13   = 12;
    localparam int F_B13  = 13;
    localparam int F_S13  = 14;

    // intervals in semitones above the root
    localparam logic [IdxW-1:0] IV_MIN2 = 4'd1;
    localparam logic [IdxW-1:0] IV_MAJ2 = 4'd2;
    localparam logic [IdxW-1:0] IV_MIN3 = 4'd3;
    localparam logic [IdxW-1:0] IV_MAJ3 = 4'd4;
    localparam logic [IdxW-1:0] IV_P4   = 4'd5;
    localparam logic [IdxW-1:0] IV_TT   = 4'd6;
    localparam logic [IdxW-1:0] IV_P5   = 4'd7;
    localparam logic [IdxW-1:0] IV_AUG5 = 4'd8;
    localparam logic [IdxW-1:0] IV_MAJ6 = 4'd9;
    localparam logic [IdxW-1:0] IV_MIN7 = 4'd10;
    localparam logic [IdxW-1:0] IV_MAJ7 = 4'd11;

endpackage

@@ rtl/csv_if.sv @@
interface csv_in_if;
    import csv_pkg::*;

    logic              valid;
    logic              ready;
    logic [RootW-1:0]  root_class;
    logic [QualW-1:0]  quality;
    logic [ExtW-1:0]   extension_flags;

    modport source (output valid, root_class, quality, extension_flags, input ready);
    modport sink   (input valid, root_class, quality, extension_flags, output ready);
endinterface

interface csv_out_if;
    import csv_pkg::*;

    logic              valid;
    logic              ready;
    logic [PitchW-1:0] pitch;
    logic              is_bass;
    logic              last;

    modport source (output valid, pitch, is_bass, last, input ready);
    modport sink   (input valid, pitch, is_bass, last, output ready);
endinterface

@@ rtl/csv_decode.sv @@
module csv_decode (
    input  logic [csv_pkg::QualW-1:0] i_quality,
    input  logic [csv_pkg::ExtW-1:0]  i_ext,
    output logic                      o_known,
    output logic [csv_pkg::NumPc-1:0] o_mask
);
    import csv_pkg::*;

    logic [IdxW-1:0] third_iv;
    logic [IdxW-1:0] fifth_iv;
    logic            has_third;
    logic            any7;

    always_comb begin
        o_known   = 1'b1;
        has_third = 1'b1;
        third_iv  = IV_MAJ3;
        fifth_iv  = IV_P5;
        unique case (i_quality)
            Q_MAJ:  begin third_iv = IV_MAJ3; fifth_iv = IV_P5;   end
            Q_MIN:  begin third_iv = IV_MIN3; fifth_iv = IV_P5;   end
            Q_DIM:  begin third_iv = IV_MIN3; fifth_iv = IV_TT;   end
            Q_HDIM: begin third_iv = IV_MIN3; fifth_iv = IV_TT;   end
            Q_AUG:  begin third_iv = IV_MAJ3; fifth_iv = IV_AUG5; end
            Q_SUS2: begin third_iv = IV_MAJ2; fifth_iv = IV_P5;   end
            Q_SUS4: begin third_iv = IV_P4;   fifth_iv = IV_P5;   end
            Q_POW:  begin has_third = 1'b0;   fifth_iv = IV_P5;   end
            default: o_known = 1'b0;
        endcase

        // b5 wins over #5, both only alter a perfect fifth
        if (fifth_iv == IV_P5) begin
            if (i_ext[F_B5]) begin
                fifth_iv = IV_TT;
            end else if (i_ext[F_S5]) begin
                fifth_iv = IV_AUG5;
            end
        end

        any7   = i_ext[F_MAJ7] | i_ext[F_MIN7] | i_ext[F_DIM7];
        o_mask = '0;
        if (has_third && !i_ext[F_OM3]) begin
            o_mask[third_iv] = 1'b1;
        end
        o_mask[fifth_iv] = 1'b1;

        priority if (i_ext[F_MAJ7]) begin
            o_mask[IV_MAJ7] = 1'b1;
        end else if (i_ext[F_MIN7]) begin
            o_mask[IV_MIN7] = 1'b1;
        end else if (i_ext[F_DIM7]) begin
            o_mask[IV_MAJ6] = 1'b1;
        end
        if (i_quality == Q_HDIM && !i_ext[F_MIN7] && !i_ext[F_MAJ7]) begin
            o_mask[IV_MIN7] = 1'b1;
        end
        if (i_ext[F_ADD6] && !any7) begin
            o_mask[IV_MAJ6] = 1'b1;
        end

        if (i_ext[F_B9])  o_mask[IV_MIN2] = 1'b1;
        if (i_ext[F_9])   o_mask[IV_MAJ2] = 1'b1;
        if (i_ext[F_S9])  o_mask[IV_MIN3] = 1'b1;
        if (i_ext[F_11])  o_mask[IV_P4]   = 1'b1;
        if (i_ext[F_S11]) o_mask[IV_TT]   = 1'b1;
        if (i_ext[F_13])  o_mask[IV_MAJ6] = 1'b1;
        if (i_ext[F_B13]) o_mask[IV_AUG5] = 1'b1;
        if (i_ext[F_S13]) o_mask[IV_MIN7] = 1'b1;
    end

endmodule

@@ rtl/chord_symbol_to_voicing.sv @@
// The bass word is registered in S_BASS, once the output is free, after a chord word is accepted.
// Chords are taken one at a time (ready only in S_IDLE): accept, bass, then one step per
// interval 1..11 through the shared pitch adder; the bass and emitted notes wait on output stalls.
// Unknown quality: the word is taken and dropped, ready again next cycle.
// Reset: synchronous, active low; clears sequencer state and output valid.
module chord_symbol_to_voicing (
    input  logic i_clk,
    input  logic i_rst_n,
    csv_in_if.sink    i_chord,
    csv_out_if.source o_note
);
    import csv_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_BASS, S_SCAN} t_state;

    t_state             r_state;
    logic [RootW-1:0]   r_root;
    logic [NumPc-1:0]   r_mask;
    logic [IdxW-1:0]    r_idx;
    logic [PitchW-1:0]  r_prev;
    logic               r_out_valid;
    logic [PitchW-1:0]  r_pitch;
    logic               r_is_bass;
    logic               r_last;

    logic               dec_known;
    logic [NumPc-1:0]   dec_mask;
    logic [RootW-1:0]   root_mod;
    logic               out_free;
    logic               out_load;
    logic [RootW:0]     pc_sum;
    logic [IdxW-1:0]    pc;
    logic [PitchW-1:0]  unit_base;
    logic [PitchW-1:0]  cand;
    logic [PitchW-1:0]  unit_pitch;
    logic [IdxW-1:0]    idx_next;
    logic               tail_empty;

    csv_decode u_decode (
        .i_quality (i_chord.quality),
        .i_ext     (i_chord.extension_flags),
        .o_known   (dec_known),
        .o_mask    (dec_mask)
    );

    assign root_mod = (i_chord.root_class >= RootW'(NumPc))
                    ? i_chord.root_class - RootW'(NumPc) : i_chord.root_class;

    // shared pitch unit: bass = 36 + root, treble = 60 + pc raised over prev
    always_comb begin
        pc_sum    = {1'b0, r_root} + {1'b0, r_idx};
        pc        = (pc_sum >= (RootW+1)'(NumPc)) ? IdxW'(pc_sum - (RootW+1)'(NumPc))
                                                  : IdxW'(pc_sum);
        unit_base = (r_state == S_BASS) ? BassBase : TrebleFloor;
        cand      = unit_base + ((r_state == S_BASS) ? PitchW'(r_root) : PitchW'(pc));
        unit_pitch = (r_state == S_SCAN && cand < r_prev) ? cand + Octave : cand;
    end

    assign idx_next   = r_idx + IdxW'(1);
    assign tail_empty = ((r_mask >> idx_next) == '0);
    assign out_free   = !r_out_valid || o_note.ready;
    assign out_load   = out_free && ((r_state == S_BASS) ||
                                     (r_state == S_SCAN && r_mask[r_idx]));

    assign i_chord.ready  = (r_state == S_IDLE);
    assign o_note.valid   = r_out_valid;
    assign o_note.pitch   = r_pitch;
    assign o_note.is_bass = r_is_bass;
    assign o_note.last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= out_load || (r_out_valid && !o_note.ready);
            unique case (r_state)
                S_IDLE: begin
                    if (i_chord.valid && dec_known) begin
                        r_root  <= root_mod;
                        r_mask  <= dec_mask;
                        r_state <= S_BASS;
                    end
                end
                S_BASS: begin
                    if (out_free) begin
                        r_pitch     <= unit_pitch;
                        r_is_bass   <= 1'b1;
                        r_last      <= (r_mask == '0);
                        r_prev      <= TrebleFloor;
                        r_idx       <= IdxW'(1);
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!r_mask[r_idx] || out_free) begin
                        if (r_mask[r_idx]) begin
                            r_pitch     <= unit_pitch;
                            r_is_bass   <= 1'b0;
                            r_last      <= tail_empty;
                            r_prev      <= unit_pitch;
                        end
                        if (r_idx == IdxW'(NumPc - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= idx_next;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
